// ===== design/wbp_pkg.sv =====
`timescale 1ns / 1ps
package wbp_pkg;

  localparam int COORD_FRAC_BITS  = 16;
  localparam int MATRIX_FRAC_BITS = 24;
  localparam int ACC_FRAC_BITS    = COORD_FRAC_BITS + MATRIX_FRAC_BITS - 2;
  localparam int TRANS_SHIFT      = COORD_FRAC_BITS - 2;
  localparam logic [63:0] VIS_THRESHOLD = 64'(((65'd1 << ACC_FRAC_BITS) + 65'd50) / 65'd100);

  // Quotient bits kept by the divider: magnitudes up to 2^40 plus one bit to see overflow.
  localparam int DIV_STEPS = 41;
  localparam int FRONT_LAT = 4;
  localparam int DIV_LAT   = DIV_STEPS + 5;
  localparam int BACK_LAT  = 6;
  localparam int TOTAL_LAT = FRONT_LAT + DIV_LAT + BACK_LAT;

  localparam logic [2:0] REG_PAIR_A = 3'd0;
  localparam logic [2:0] REG_PAIR_B = 3'd1;
  localparam logic [2:0] REG_PAIR_C = 3'd2;
  localparam logic [2:0] REG_PAIR_D = 3'd3;
  localparam logic [2:0] REG_PAIR_E = 3'd4;
  localparam logic [2:0] REG_PAIR_F = 3'd5;
  localparam logic [2:0] REG_HALF_W = 3'd6;
  localparam logic [2:0] REG_HALF_H = 3'd7;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] lower_offset;
    logic signed [31:0] upper_offset;
    logic [15:0]        width_ratio;
  } item_t;

  typedef struct packed {
    logic               visible;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic signed [31:0] box_left;
    logic signed [31:0] box_top;
    logic signed [31:0] box_half_width;
    logic signed [31:0] box_height;
    logic               saturated;
  } result_t;

  typedef struct packed {
    logic signed [31:0] m0;
    logic signed [31:0] m1;
    logic signed [31:0] m3;
    logic signed [31:0] m4;
    logic signed [31:0] m5;
    logic signed [31:0] m7;
    logic signed [31:0] m8;
    logic signed [31:0] m9;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m13;
    logic signed [31:0] m15;
    logic [27:0]        half_w;
    logic [27:0]        half_h;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic               vis;
    logic [15:0]        ratio;
    logic signed [63:0] nx;
    logic signed [63:0] ny;
    logic signed [63:0] nlo;
    logic signed [63:0] nup;
    logic [63:0]        w;
  } front_t;

  // Bit 32 is the clamp flag, bits 31:0 the clamped value.
  function automatic logic [32:0] sat32(input logic signed [63:0] v);
    logic [32:0] r;
    if (v > 64'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -64'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

// ===== design/wbp_cfg.sv =====
`timescale 1ns / 1ps
module wbp_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [5:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready,
  output wbp_pkg::cfg_t cfg
);
  import wbp_pkg::*;

  logic [63:0] pair [6];
  logic [27:0] half_w;
  logic [27:0] half_h;
  logic [2:0]  idx;
  logic        wr;

  assign idx    = paddr[5:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) pair[i] <= '0;
      half_w <= '0;
      half_h <= '0;
    end else if (wr) begin
      case (idx)
        REG_PAIR_A: pair[0] <= pwdata;
        REG_PAIR_B: pair[1] <= pwdata;
        REG_PAIR_C: pair[2] <= pwdata;
        REG_PAIR_D: pair[3] <= pwdata;
        REG_PAIR_E: pair[4] <= pwdata;
        REG_PAIR_F: pair[5] <= pwdata;
        REG_HALF_W: half_w <= pwdata[27:0];
        REG_HALF_H: half_h <= pwdata[27:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PAIR_A: prdata = pair[0];
      REG_PAIR_B: prdata = pair[1];
      REG_PAIR_C: prdata = pair[2];
      REG_PAIR_D: prdata = pair[3];
      REG_PAIR_E: prdata = pair[4];
      REG_PAIR_F: prdata = pair[5];
      REG_HALF_W: prdata = {36'd0, half_w};
      REG_HALF_H: prdata = {36'd0, half_h};
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    cfg.m0     = pair[0][31:0];
    cfg.m1     = pair[0][63:32];
    cfg.m3     = pair[1][31:0];
    cfg.m4     = pair[1][63:32];
    cfg.m5     = pair[2][31:0];
    cfg.m7     = pair[2][63:32];
    cfg.m8     = pair[3][31:0];
    cfg.m9     = pair[3][63:32];
    cfg.m11    = pair[4][31:0];
    cfg.m12    = pair[4][63:32];
    cfg.m13    = pair[5][31:0];
    cfg.m15    = pair[5][63:32];
    cfg.half_w = half_w;
    cfg.half_h = half_h;
  end
endmodule

// ===== design/wbp_front.sv =====
`timescale 1ns / 1ps
module wbp_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  wbp_pkg::item_t  item,
  input  wbp_pkg::cfg_t   cfg,
  output wbp_pkg::front_t fo
);
  import wbp_pkg::*;

  logic signed [63:0] p0x, p4y, p8z, p1x, p5y, p9z, p3x, p7y, p11z, p9lo, p9up;
  logic signed [63:0] t0x, t4y, t8z, t1x, t5y, t9z, t3x, t7y, t11z, t9lo, t9up;
  logic signed [63:0] tr12, tr13, tr15;
  logic signed [63:0] ax, bx, ay, by, aw, bw, lo2, up2;
  logic signed [63:0] nx3, ny3, w3, lo3, up3;
  logic        v1, v2, v3;
  logic [15:0] r1, r2, r3;

  always_comb begin
    p0x  = $signed(cfg.m0)  * $signed(item.pos_x);
    p4y  = $signed(cfg.m4)  * $signed(item.pos_y);
    p8z  = $signed(cfg.m8)  * $signed(item.pos_z);
    p1x  = $signed(cfg.m1)  * $signed(item.pos_x);
    p5y  = $signed(cfg.m5)  * $signed(item.pos_y);
    p9z  = $signed(cfg.m9)  * $signed(item.pos_z);
    p3x  = $signed(cfg.m3)  * $signed(item.pos_x);
    p7y  = $signed(cfg.m7)  * $signed(item.pos_y);
    p11z = $signed(cfg.m11) * $signed(item.pos_z);
    p9lo = $signed(cfg.m9)  * $signed(item.lower_offset);
    p9up = $signed(cfg.m9)  * $signed(item.upper_offset);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      fo.valid <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
      fo.valid <= v3;
    end

    // Products are floored by two bits; translations are scaled up to the same point.
    t0x  <= p0x >>> 2;
    t4y  <= p4y >>> 2;
    t8z  <= p8z >>> 2;
    t1x  <= p1x >>> 2;
    t5y  <= p5y >>> 2;
    t9z  <= p9z >>> 2;
    t3x  <= p3x >>> 2;
    t7y  <= p7y >>> 2;
    t11z <= p11z >>> 2;
    t9lo <= p9lo >>> 2;
    t9up <= p9up >>> 2;
    tr12 <= 64'(cfg.m12) <<< TRANS_SHIFT;
    tr13 <= 64'(cfg.m13) <<< TRANS_SHIFT;
    tr15 <= 64'(cfg.m15) <<< TRANS_SHIFT;
    r1   <= item.width_ratio;

    ax  <= t0x + t4y;
    bx  <= t8z + tr12;
    ay  <= t1x + t5y;
    by  <= t9z + tr13;
    aw  <= t3x + t7y;
    bw  <= t11z + tr15;
    lo2 <= t9lo;
    up2 <= t9up;
    r2  <= r1;

    nx3 <= ax + bx;
    ny3 <= ay + by;
    w3  <= aw + bw;
    lo3 <= lo2;
    up3 <= up2;
    r3  <= r2;

    fo.nx    <= nx3;
    fo.ny    <= ny3;
    fo.nlo   <= ny3 + lo3;
    fo.nup   <= ny3 + up3;
    fo.w     <= w3;
    fo.vis   <= !w3[63] && (w3 > VIS_THRESHOLD);
    fo.ratio <= r3;
  end
endmodule

// ===== design/wbp_div.sv =====
`timescale 1ns / 1ps
module wbp_div (
  input  logic               clk,
  input  logic signed [63:0] n,
  input  logic [27:0]        c,
  input  logic [63:0]        w,
  output logic signed [41:0] q,
  output logic               sat
);
  import wbp_pkg::*;

  logic [63:0] mag0, w0, w1, w2;
  logic [27:0] c0;
  logic        neg0, neg1, neg2;
  logic [59:0] pp_lo, pp_hi;
  logic [91:0] prod;

  logic [63:0]          rem_s [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] q_s   [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] low_s [DIV_STEPS+1];
  logic [63:0]          w_s   [DIV_STEPS+1];
  logic                 ov_s  [DIV_STEPS+1];
  logic                 neg_s [DIV_STEPS+1];
  logic [63:0]          trial [DIV_STEPS];
  logic                 ge    [DIV_STEPS];

  logic                 big;
  logic [DIV_STEPS-1:0] qmag;
  localparam logic [DIV_STEPS-1:0] QLIMIT = DIV_STEPS'(1) << (DIV_STEPS - 1);

  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial[k] = {rem_s[k][62:0], low_s[k][DIV_STEPS-1-k]};
      ge[k]    = trial[k] >= w_s[k];
    end
  end

  always_ff @(posedge clk) begin
    neg0 <= n[63];
    mag0 <= n[63] ? 64'(-n) : 64'(n);
    c0   <= c;
    w0   <= w;

    pp_lo <= 60'(mag0[31:0]) * 60'(c0);
    pp_hi <= 60'(mag0[63:32]) * 60'(c0);
    neg1  <= neg0;
    w1    <= w0;

    prod <= 92'(pp_lo) + (92'(pp_hi) << 32);
    neg2 <= neg1;
    w2   <= w1;

    // A quotient of 2^41 or more saturates in any case.
    ov_s[0]  <= 105'(prod) >= {w2, 41'd0};
    rem_s[0] <= 64'(prod[91:DIV_STEPS]);
    low_s[0] <= prod[DIV_STEPS-1:0];
    q_s[0]   <= '0;
    w_s[0]   <= w2;
    neg_s[0] <= neg2;

    for (int k = 0; k < DIV_STEPS; k++) begin
      rem_s[k+1] <= ge[k] ? trial[k] - w_s[k] : trial[k];
      q_s[k+1]   <= {q_s[k][DIV_STEPS-2:0], ge[k]};
      low_s[k+1] <= low_s[k];
      w_s[k+1]   <= w_s[k];
      ov_s[k+1]  <= ov_s[k];
      neg_s[k+1] <= neg_s[k];
    end
  end

  always_comb begin
    big  = ov_s[DIV_STEPS] || (q_s[DIV_STEPS] > QLIMIT);
    qmag = big ? QLIMIT : q_s[DIV_STEPS];
  end

  always_ff @(posedge clk) begin
    sat <= big;
    q   <= neg_s[DIV_STEPS] ? -$signed(42'(qmag)) : $signed(42'(qmag));
  end
endmodule

// ===== design/wbp_back.sv =====
`timescale 1ns / 1ps
module wbp_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid,
  input  logic               vis,
  input  logic [15:0]        ratio,
  input  logic [27:0]        half_w,
  input  logic [27:0]        half_h,
  input  logic signed [41:0] qx,
  input  logic signed [41:0] qy,
  input  logic signed [41:0] qlo,
  input  logic signed [41:0] qup,
  input  logic [3:0]         qsat,
  output logic               done,
  output wbp_pkg::result_t   result
);
  import wbp_pkg::*;

  logic [BACK_LAT-2:0] vld;
  logic [BACK_LAT-2:0] vs;
  logic [BACK_LAT-2:0] st;
  logic [15:0] r1, r2;
  logic signed [42:0] sx1, sy1, ylo1, yup1, sx2, sy2, yup2, sx3, sy3, yup3;
  logic signed [42:0] sx4, sy4, yup4;
  logic signed [43:0] ht2, ht3, ht4, ht5;
  logic [41:0]        pl;
  logic signed [34:0] ph;
  logic signed [60:0] wide;
  logic signed [47:0] hw4, hw5;
  logic signed [48:0] left5;
  logic signed [42:0] sx5, sy5, yup5;
  logic [32:0] s_x, s_y, s_l, s_t, s_h, s_g;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[BACK_LAT-3:0], valid};
      done <= vld[BACK_LAT-2];
    end
  end

  always_ff @(posedge clk) begin
    vs <= {vs[BACK_LAT-3:0], vis};
    st[0] <= |qsat;
    st[BACK_LAT-2:1] <= st[BACK_LAT-3:0];
    r1 <= ratio;
    r2 <= r1;

    sx1  <= $signed({15'd0, half_w}) + 43'(qx);
    sy1  <= $signed({15'd0, half_h}) - 43'(qy);
    ylo1 <= $signed({15'd0, half_h}) - 43'(qlo);
    yup1 <= $signed({15'd0, half_h}) - 43'(qup);

    ht2  <= 44'(ylo1) - 44'(yup1);
    sx2  <= sx1;
    sy2  <= sy1;
    yup2 <= yup1;

    pl   <= 42'(ht2[25:0]) * 42'(r2);
    ph   <= $signed(ht2[43:26]) * $signed({1'b0, r2});
    ht3  <= ht2;
    sx3  <= sx2;
    sy3  <= sy2;
    yup3 <= yup2;

    hw4  <= 48'(wide >>> 13);
    ht4  <= ht3;
    sx4  <= sx3;
    sy4  <= sy3;
    yup4 <= yup3;

    left5 <= 49'(sx4) - 49'(hw4);
    hw5   <= hw4;
    ht5   <= ht4;
    sx5   <= sx4;
    sy5   <= sy4;
    yup5  <= yup4;
  end

  assign wide = (61'(ph) <<< 26) + $signed(61'(pl));

  always_comb begin
    s_x = sat32(64'(sx5));
    s_y = sat32(64'(sy5));
    s_l = sat32(64'(left5));
    s_t = sat32(64'(yup5));
    s_h = sat32(64'(hw5));
    s_g = sat32(64'(ht5));
  end

  always_ff @(posedge clk) begin
    if (vs[BACK_LAT-2]) begin
      result.visible        <= 1'b1;
      result.screen_x       <= s_x[31:0];
      result.screen_y       <= s_y[31:0];
      result.box_left       <= s_l[31:0];
      result.box_top        <= s_t[31:0];
      result.box_half_width <= s_h[31:0];
      result.box_height     <= s_g[31:0];
      result.saturated      <= st[BACK_LAT-2] | s_x[32] | s_y[32] | s_l[32] | s_t[32]
                               | s_h[32] | s_g[32];
    end else begin
      result <= '0;
    end
  end
endmodule

// ===== design/world_to_box_projection.sv =====
`timescale 1ns / 1ps
// Channel   | Ports                                   | Handshake
// ----------+-----------------------------------------+---------------------------------
// item      | start, busy, item                       | word taken when start && !busy
// result    | done, result                            | word valid for the one done cycle
// config    | psel, penable, pwrite, paddr, pwdata,   | APB write on access phase,
//           | prdata, pready                          | register i at byte address 8*i
//
// One word is taken every cycle; busy is held low. Each result passes through
// the matrix products and sums, then the four parallel dividers (one quotient
// bit per stage), and then the box arithmetic and saturation.
// Reset is synchronous and clears the valid line and the configuration registers.
// The receiver cannot stall, so there is no back pressure anywhere.
module world_to_box_projection (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  wbp_pkg::item_t   item,
  output logic             done,
  output wbp_pkg::result_t result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [5:0]       paddr,
  input  logic [63:0]      pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
  import wbp_pkg::*;

  cfg_t   cfg;
  front_t fo;

  logic signed [41:0] qx, qy, qlo, qup;
  logic [3:0]         qsat;

  // Side information that rides alongside the dividers.
  logic        vld_line [DIV_LAT];
  logic        vis_line [DIV_LAT];
  logic [15:0] rat_line [DIV_LAT];

  assign busy = 1'b0;

  wbp_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  wbp_front u_front (
    .clk(clk), .rst(rst), .start(start && !busy), .item(item), .cfg(cfg), .fo(fo)
  );

  // The point and both box edges each need their own quotient by the clip depth.
  wbp_div u_div_x (
    .clk(clk), .n(fo.nx), .c(cfg.half_w), .w(fo.w), .q(qx), .sat(qsat[0])
  );
  wbp_div u_div_y (
    .clk(clk), .n(fo.ny), .c(cfg.half_h), .w(fo.w), .q(qy), .sat(qsat[1])
  );
  wbp_div u_div_lo (
    .clk(clk), .n(fo.nlo), .c(cfg.half_h), .w(fo.w), .q(qlo), .sat(qsat[2])
  );
  wbp_div u_div_up (
    .clk(clk), .n(fo.nup), .c(cfg.half_h), .w(fo.w), .q(qup), .sat(qsat[3])
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) vld_line[i] <= 1'b0;
    end else begin
      vld_line[0] <= fo.valid;
      for (int i = 1; i < DIV_LAT; i++) vld_line[i] <= vld_line[i-1];
    end
  end

  always_ff @(posedge clk) begin
    vis_line[0] <= fo.vis;
    rat_line[0] <= fo.ratio;
    for (int i = 1; i < DIV_LAT; i++) begin
      vis_line[i] <= vis_line[i-1];
      rat_line[i] <= rat_line[i-1];
    end
  end

  wbp_back u_back (
    .clk(clk), .rst(rst), .valid(vld_line[DIV_LAT-1]), .vis(vis_line[DIV_LAT-1]),
    .ratio(rat_line[DIV_LAT-1]), .half_w(cfg.half_w), .half_h(cfg.half_h),
    .qx(qx), .qy(qy), .qlo(qlo), .qup(qup), .qsat(qsat),
    .done(done), .result(result)
  );

  // Every result comes from a word taken a fixed number of cycles before.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, TOTAL_LAT))
    else $error("result without a matching word");

  // A hidden position gives an all-zero result.
  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.visible) |-> (result == '0))
    else $error("hidden result carries data");

  // No result leaves in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result right after reset");
endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import wbp_pkg::*;

  // Register file seen by the bench: six matrix pairs, then the two screen centers.
  localparam int N_REGS = 8;
  localparam int LIMIT_CYCLES = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  item_t item = '0;
  logic done;
  result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  world_to_box_projection u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The bench keeps its own copy of the matrix and the screen centers.
  logic signed [63:0] mtx [16];
  logic [63:0] cen_w, cen_h;

  item_t pending_items [$];
  int unsigned pending_gaps [$];
  result_t expected_boxes [$];
  int errors = 0;
  int cycle_count = 0;

  // Matrix product with its two extra fraction bits dropped by floor.
  function automatic logic signed [63:0] mterm(logic signed [63:0] m, logic signed [63:0] v);
    logic signed [63:0] p;
    p = m * v;
    return p >>> 2;
  endfunction

  // sign(n) * trunc(|n| * c / w), magnitude limited to 2^40.
  function automatic logic signed [63:0] divide_clamped(logic signed [63:0] n,
      logic [63:0] c, logic [63:0] w, inout logic sat);
    logic [127:0] mag, q;
    mag = n < 0 ? 128'(-n) : 128'(n);
    q = (mag * 128'(c)) / 128'(w);
    if (q > (128'd1 << 40)) begin
      q = 128'd1 << 40;
      sat = 1'b1;
    end
    return n < 0 ? -$signed(64'(q)) : $signed(64'(q));
  endfunction

  function automatic logic [31:0] clamp32(logic signed [63:0] v, inout logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic result_t project_box(item_t it);
    result_t r;
    logic signed [63:0] x, y, z, w, nx, ny, qx, qy, qlo, qup;
    logic signed [63:0] sx, ylo, yup, height, halfw;
    logic sat;
    logic [63:0] thr;
    thr = ((64'd1 << ACC_FRAC_BITS) + 64'd50) / 64'd100;
    x = it.pos_x;
    y = it.pos_y;
    z = it.pos_z;
    sat = 1'b0;
    r = '0;
    w = mterm(mtx[3], x) + mterm(mtx[7], y) + mterm(mtx[11], z)
        + (mtx[15] <<< (COORD_FRAC_BITS - 2));
    if (w <= 0 || w <= $signed(thr)) return r;
    nx = mterm(mtx[0], x) + mterm(mtx[4], y) + mterm(mtx[8], z)
         + (mtx[12] <<< (COORD_FRAC_BITS - 2));
    ny = mterm(mtx[1], x) + mterm(mtx[5], y) + mterm(mtx[9], z)
         + (mtx[13] <<< (COORD_FRAC_BITS - 2));
    qx = divide_clamped(nx, cen_w, w, sat);
    qy = divide_clamped(ny, cen_h, w, sat);
    qlo = divide_clamped(ny + mterm(mtx[9], 64'(it.lower_offset)), cen_h, w, sat);
    qup = divide_clamped(ny + mterm(mtx[9], 64'(it.upper_offset)), cen_h, w, sat);
    sx = $signed(cen_w) + qx;
    ylo = $signed(cen_h) - qlo;
    yup = $signed(cen_h) - qup;
    height = ylo - yup;
    halfw = (height * $signed({48'd0, it.width_ratio})) >>> 13;
    r.visible = 1'b1;
    r.screen_x = clamp32(sx, sat);
    r.screen_y = clamp32($signed(cen_h) - qy, sat);
    r.box_left = clamp32(sx - halfw, sat);
    r.box_top = clamp32(yup, sat);
    r.box_half_width = clamp32(halfw, sat);
    r.box_height = clamp32(height, sat);
    r.saturated = sat;
    return r;
  endfunction

  function automatic void shadow_write(int idx, logic [63:0] v);
    int slot [12] = '{0, 1, 3, 4, 5, 7, 8, 9, 11, 12, 13, 15};
    if (idx < 6) begin
      mtx[slot[2*idx]] = $signed(v[31:0]);
      mtx[slot[2*idx+1]] = $signed(v[63:32]);
    end else if (idx == REG_HALF_W) begin
      cen_w = {36'd0, v[27:0]};
    end else if (idx == REG_HALF_H) begin
      cen_h = {36'd0, v[27:0]};
    end
  endfunction

  // Two-phase APB write, driven on falling edges, committed at the access edge.
  task automatic reg_write(int idx, logic [63:0] v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 6'(idx * 8);
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    shadow_write(idx, v);
  endtask

  // Driver: one word per queue entry, after its drawn gap. start stays high across
  // back-to-back words so it is never lowered and raised in one step.
  int unsigned gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && busy) begin
      // Word not yet taken; hold it.
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start <= 1'b0;
    end else if (pending_items.size() > 0 && (!start || pending_gaps[0] == 0)) begin
      item <= pending_items[0];
      start <= 1'b1;
      void'(pending_items.pop_front());
      void'(pending_gaps.pop_front());
    end else if (pending_items.size() > 0) begin
      gap_left <= pending_gaps[0] - 1;
      pending_gaps[0] = 0;
      start <= 1'b0;
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: predict at acceptance, compare each result word with the oldest expectation.
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst) begin
      cycle_count <= cycle_count + 1;
      if (start && !busy) expected_boxes.push_back(project_box(item));
      if (done) begin
        if (expected_boxes.size() == 0) begin
          $error("unexpected result word");
          errors++;
        end else begin
          exp_r = expected_boxes.pop_front();
          if (result.visible !== exp_r.visible) begin
            $error("visible exp %0d got %0d", exp_r.visible, result.visible);
            errors++;
          end
          if (result.screen_x !== exp_r.screen_x) begin
            $error("screen_x exp %0d got %0d", exp_r.screen_x, result.screen_x);
            errors++;
          end
          if (result.screen_y !== exp_r.screen_y) begin
            $error("screen_y exp %0d got %0d", exp_r.screen_y, result.screen_y);
            errors++;
          end
          if (result.box_left !== exp_r.box_left) begin
            $error("box_left exp %0d got %0d", exp_r.box_left, result.box_left);
            errors++;
          end
          if (result.box_top !== exp_r.box_top) begin
            $error("box_top exp %0d got %0d", exp_r.box_top, result.box_top);
            errors++;
          end
          if (result.box_half_width !== exp_r.box_half_width) begin
            $error("box_half_width exp %0d got %0d", exp_r.box_half_width,
                   result.box_half_width);
            errors++;
          end
          if (result.box_height !== exp_r.box_height) begin
            $error("box_height exp %0d got %0d", exp_r.box_height, result.box_height);
            errors++;
          end
          if (result.saturated !== exp_r.saturated) begin
            $error("saturated exp %0d got %0d", exp_r.saturated, result.saturated);
            errors++;
          end
        end
      end
      if (cycle_count > LIMIT_CYCLES) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(int'($urandom_range(0, 2000)) - 1000) << 16;
      3: return 32'(int'($urandom_range(0, 200)) - 100) << 16;
      default: return $urandom;
    endcase
  endfunction

  // Most words are ordinary positions near the origin with small offsets.
  function automatic item_t rand_item();
    item_t it;
    if ($urandom_range(0, 9) < 8) begin
      it.pos_x = (int'($urandom_range(0, 400)) - 200) <<< 16 | $urandom_range(0, 65535);
      it.pos_y = (int'($urandom_range(0, 400)) - 200) <<< 16 | $urandom_range(0, 65535);
      it.pos_z = (int'($urandom_range(0, 400)) - 200) <<< 16 | $urandom_range(0, 65535);
      it.lower_offset = -(int'($urandom_range(0, 4 << 16)));
      it.upper_offset = int'($urandom_range(0, 4 << 16));
    end else begin
      it.pos_x = rand_word();
      it.pos_y = rand_word();
      it.pos_z = rand_word();
      it.lower_offset = rand_word();
      it.upper_offset = rand_word();
    end
    it.width_ratio = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 8192));
    return it;
  endfunction

  task automatic queue_item(item_t it, bit no_gap);
    pending_items.push_back(it);
    pending_gaps.push_back(no_gap || $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12));
  endtask

  // Lets every queued word go out and every expected result arrive, then the
  // pipeline depth on top since a phase change must not catch words in flight.
  task automatic drain();
    while (pending_items.size() > 0 || start || expected_boxes.size() > 0) @(posedge clk);
    repeat (TOTAL_LAT + 4) @(posedge clk);
  endtask

  // Q8.24 entry with a given value in units of 1/256.
  function automatic logic [31:0] q24(int v256);
    return 32'(v256) <<< 16;
  endfunction

  // Camera-like matrix: w follows z and y plus a fixed offset, ny picks up z through m9.
  task automatic load_camera(int scale, int cw, int ch);
    reg_write(REG_PAIR_A, {q24(0), q24(scale)});
    reg_write(REG_PAIR_B, {q24(0), q24(0)});
    reg_write(REG_PAIR_C, {q24(16), q24(0)});
    reg_write(REG_PAIR_D, {q24(scale), q24(0)});
    reg_write(REG_PAIR_E, {q24(0), q24(64)});
    reg_write(REG_PAIR_F, {q24(256 * 250), q24(0)});
    reg_write(REG_HALF_W, 64'(cw));
    reg_write(REG_HALF_H, 64'(ch));
  endtask

  initial begin
    item_t it;
    logic [63:0] rv;
    for (int i = 0; i < 16; i++) mtx[i] = '0;
    cen_w = '0;
    cen_h = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // With everything at reset the depth is zero, so every word is not visible.
    it = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF};
    queue_item(it, 1'b1);
    drain();

    load_camera(256, 960 << 16, 540 << 16);
    // Directed: extremes and negative depth.
    queue_item('{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0}, 1'b1);
    queue_item('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 16'hFFFF}, 1'b1);
    queue_item('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 16'hFFFF}, 1'b1);
    queue_item('{32'(10 << 16), 32'd0, 32'(-250 << 16), 32'd0, 32'd0, 16'd4096}, 1'b0);
    queue_item('{32'd0, 32'd0, 32'(-250 << 16) + 32'd656, 32'd0, 32'd0, 16'd4096}, 1'b0);
    queue_item('{32'd0, 32'd0, 32'(-250 << 16) + 32'd660, 32'(-1 << 16),
                 32'(1 << 16), 16'd4096}, 1'b0);
    queue_item('{32'(5 << 16), 32'd7, 32'(-249 << 16), 32'(-2 << 16),
                 32'(2 << 16), 16'hFFFF}, 1'b0);
    queue_item('{32'(3 << 16), 32'(1 << 16), 32'(-400 << 16), 32'd0, 32'd0, 16'd1}, 1'b0);
    queue_item('{32'(-20 << 16), 32'(9 << 16), 32'(100 << 16), 32'h8000_0000,
                 32'h7FFF_FFFF, 16'd8192}, 1'b0);
    for (int i = 0; i < 6; i++) queue_item(rand_item(), 1'b0);
    drain();

    // Register read-back while idle.
    for (int i = 0; i < N_REGS; i++) begin
      @(negedge clk);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= 6'(i * 8);
      @(negedge clk);
      penable <= 1'b1;
      @(posedge clk);
      rv = i < 6 ? {mtx[i < 1 ? 1 : i < 2 ? 4 : i < 3 ? 7 : i < 4 ? 9 : i < 5 ? 12 : 15][31:0],
                    mtx[i < 1 ? 0 : i < 2 ? 3 : i < 3 ? 5 : i < 4 ? 8 : i < 5 ? 11 : 13][31:0]}
                 : (i == REG_HALF_W ? cen_w : cen_h);
      if (prdata !== rv) begin
        $error("prdata exp %0h got %0h", rv, prdata);
        errors++;
      end
      @(negedge clk);
      psel <= 1'b0;
      penable <= 1'b0;
    end

    // Random phases over several settings, including the register extremes.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_camera(256, 960 << 16, 540 << 16);
        1: load_camera(1 << 14, 28'hFFF_FFFF, 28'hFFF_FFFF);
        2: load_camera(4, 1, 0);
        3: for (int r = 0; r < 6; r++) reg_write(r, {$urandom, $urandom});
        4: begin
          for (int r = 0; r < 6; r++) reg_write(r, 64'hFFFF_FFFF_FFFF_FFFF);
          reg_write(REG_PAIR_F, 64'h7FFF_FFFF_8000_0000);
          reg_write(REG_HALF_W, 64'hFFFF_FFFF_FFFF_FFFF);
          reg_write(REG_HALF_H, 64'h0);
        end
        default: begin
          load_camera(128, 640 << 16, 360 << 16);
          reg_write(REG_PAIR_B, {q24(-40), q24(3)});
        end
      endcase
      for (int i = 0; i < 250; i++) begin
        queue_item(rand_item(), i < 40);
        // Once per phase the sender stops until the pipeline is empty.
        if (i == 120) drain();
      end
      drain();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
